@@ sv/fcdr_pkg.sv @@
// Shared types and constants for the frame cache tag table.
`timescale 1ns / 1ps
`default_nettype none

package fcdr_pkg;

    localparam int FRAME_W   = 31;
    localparam int BYTES_W   = 26;
    localparam int FMT_W     = 8;
    localparam int REQ_W     = 2;
    localparam int IDX_OUT_W = 4;
    localparam int MIB_W     = 10;
    localparam int MIB_SHIFT = 20;
    localparam int SCORE_W   = FRAME_W + 1;

    localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [BYTES_W-1:0] nbytes;
        logic [FMT_W-1:0]   fmt;
    } entry_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic rd_en;
        logic write;
        logic sub;
        logic add;
        logic load;
    } cmd_t;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic in_scan;
        logic in_clear;
        logic req_store;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/fcdr_ctrl.sv @@
// Request sequencer: accept, slot scan, write-back, result handoff.
`timescale 1ns / 1ps
`default_nettype none

module fcdr_ctrl
    import fcdr_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire stat_t                 st,
    output cmd_t                       cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             in_fire;
    logic             scan_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign scan_last = (cnt_reg == CNT_W'(SLOTS));
    assign rd_addr   = cnt_reg[SLOT_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        cmd.capture = in_fire;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cnt_next  = '0;
                    cmd.clear = st.in_clear;
                    state_next = st.in_scan ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = !scan_last;
                if (scan_last)
                    state_next = st.req_store ? S_WRITE : S_RESP;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                cmd.sub    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add    = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (st.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= CNT_W'(SLOTS)))
        else $error("scan counter ran past the last slot");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    a_write_then_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE) |=> (state_reg == S_ADD))
        else $error("write-back not followed by the byte add");

endmodule

`default_nettype wire

@@ sv/fcdr_dp.sv @@
// Tag table datapath: slot memory, valid bits, scan accumulators, byte total.
`timescale 1ns / 1ps
`default_nettype none

module fcdr_dp
    import fcdr_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [FRAME_W-1:0]   frame_number,
    input  wire logic [BYTES_W-1:0]   frame_bytes,
    input  wire logic [FMT_W-1:0]     frame_format,
    input  wire logic                 out_ready,
    output stat_t                     st,
    output logic                      out_valid,
    output logic                      hit,
    output logic                      stored,
    output logic [IDX_OUT_W-1:0]      slot_id,
    output logic [BYTES_W-1:0]        held_bytes,
    output logic [FMT_W-1:0]          held_format,
    output logic [MIB_W-1:0]          total_mib
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOT_W  = BYTES_W + $clog2(SLOTS + 1);

    // request capture
    logic [REQ_W-1:0]   req_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [FMT_W-1:0]   fmt_reg;

    // slot store
    entry_t             mem [SLOTS];
    entry_t             rd_data_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               rd_vld_reg;
    logic               rd_valid_reg;
    logic [SLOT_W-1:0]  rd_idx_reg;

    // scan accumulators
    logic               free_found_reg;
    logic [SLOT_W-1:0]  free_idx_reg;
    logic [SCORE_W-1:0] best_score_reg;
    logic [SLOT_W-1:0]  best_idx_reg;
    logic [BYTES_W-1:0] best_bytes_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  hit_idx_reg;
    logic [BYTES_W-1:0] hit_bytes_reg;
    logic [FMT_W-1:0]   hit_fmt_reg;
    logic [SLOT_W-1:0]  wslot_reg;

    logic [TOT_W-1:0]   total_reg;

    // output register
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic               out_stored_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    logic [BYTES_W-1:0] out_bytes_reg;
    logic [FMT_W-1:0]   out_fmt_reg;
    logic [MIB_W-1:0]   out_mib_reg;

    logic [FRAME_W-1:0] ahead_diff;
    logic [FRAME_W-1:0] behind_diff;
    logic               tag_ahead;
    logic [SCORE_W-1:0] score;
    logic [SLOT_W-1:0]  wslot;
    logic               store_done;
    logic               lookup_req;
    logic [SLOT_W-1:0]  res_idx;
    logic [SLOT_W+IDX_OUT_W-1:0] res_idx_ext;
    logic [TOT_W+MIB_W-1:0] tot_ext;
    logic               mib_sat;
    logic [MIB_W-1:0]   mib;
    logic               out_fire;

    assign st.in_scan   = (req_type == REQ_LOOKUP)
                       || ((req_type == REQ_STORE) && (frame_bytes != '0));
    assign st.in_clear  = (req_type == REQ_CLEAR);
    assign st.req_store = (req_reg == REQ_STORE);
    assign st.out_free  = !out_valid_reg || out_ready;

    // distance score of the slot just read
    assign tag_ahead   = (rd_data_reg.frame >= frame_reg);
    assign ahead_diff  = rd_data_reg.frame - frame_reg;
    assign behind_diff = frame_reg - rd_data_reg.frame;
    assign score       = tag_ahead ? {1'b0, ahead_diff} : {behind_diff, 1'b0};

    assign wslot       = free_found_reg ? free_idx_reg : best_idx_reg;
    assign store_done  = (req_reg == REQ_STORE) && (bytes_reg != '0);
    assign lookup_req  = (req_reg == REQ_LOOKUP);
    assign res_idx     = store_done ? wslot_reg : hit_idx_reg;
    assign res_idx_ext = {{IDX_OUT_W{1'b0}}, res_idx};

    assign tot_ext = {{MIB_W{1'b0}}, total_reg};
    assign mib_sat = |tot_ext[TOT_W+MIB_W-1:MIB_SHIFT+MIB_W];
    assign mib     = mib_sat ? {MIB_W{1'b1}} : tot_ext[MIB_SHIFT+MIB_W-1:MIB_SHIFT];

    assign out_fire = out_valid_reg && out_ready;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            frame_reg <= frame_number;
            bytes_reg <= frame_bytes;
            fmt_reg   <= frame_format;
        end
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.write)
        begin
            mem[wslot] <= '{frame: frame_reg, nbytes: bytes_reg, fmt: fmt_reg};
            wslot_reg  <= wslot;
        end
        rd_idx_reg   <= rd_addr;
        rd_valid_reg <= valid_reg[rd_addr];
        if (rd_vld_reg)
        begin
            if (!free_found_reg && !rd_valid_reg)
                free_idx_reg <= rd_idx_reg;
            if ((rd_idx_reg == '0) || (score > best_score_reg))
            begin
                best_score_reg <= score;
                best_idx_reg   <= rd_idx_reg;
                best_bytes_reg <= rd_data_reg.nbytes;
            end
            if (!hit_reg && rd_valid_reg && (rd_data_reg.frame == frame_reg))
            begin
                hit_idx_reg   <= rd_idx_reg;
                hit_bytes_reg <= rd_data_reg.nbytes;
                hit_fmt_reg   <= rd_data_reg.fmt;
            end
        end
        if (cmd.load)
        begin
            out_hit_reg    <= lookup_req && hit_reg;
            out_stored_reg <= store_done;
            out_idx_reg    <= (store_done || (lookup_req && hit_reg))
                              ? res_idx_ext[IDX_OUT_W-1:0] : '0;
            out_bytes_reg  <= (lookup_req && hit_reg) ? hit_bytes_reg : '0;
            out_fmt_reg    <= (lookup_req && hit_reg) ? hit_fmt_reg : '0;
            out_mib_reg    <= mib;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            total_reg      <= '0;
            rd_vld_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.capture)
            begin
                free_found_reg <= 1'b0;
                hit_reg        <= 1'b0;
            end
            else if (rd_vld_reg)
            begin
                if (!rd_valid_reg)
                    free_found_reg <= 1'b1;
                if (rd_valid_reg && (rd_data_reg.frame == frame_reg))
                    hit_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                valid_reg <= '0;
                total_reg <= '0;
            end
            else if (cmd.sub)
            begin
                valid_reg[wslot] <= 1'b1;
                if (!free_found_reg)
                    total_reg <= total_reg - TOT_W'(best_bytes_reg);
            end
            else if (cmd.add)
            begin
                total_reg <= total_reg + TOT_W'(bytes_reg);
            end
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = out_hit_reg;
    assign stored      = out_stored_reg;
    assign slot_id     = out_idx_reg;
    assign held_bytes  = out_bytes_reg;
    assign held_format = out_fmt_reg;
    assign total_mib   = out_mib_reg;

    a_hit_xor_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_stored_reg))
        else $error("result flags both a hit and a store");

    a_miss_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> ((out_bytes_reg == '0) && (out_fmt_reg == '0)))
        else $error("slot fields present without a hit");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> ((total_reg == '0) && (valid_reg == '0)))
        else $error("clear left slots or bytes behind");

endmodule

`default_nettype wire

@@ sv/frame_cache_distance_replacement.sv @@
// Top level of the frame cache tag table: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Frame cache tag table with distance-based replacement. Each transfer on the
// input channel is one request: store (req_type 0), lookup (1) or clear (2);
// code 3 changes nothing. A store of nonzero size fills the lowest empty slot,
// or, with every slot full, evicts the slot whose frame number scores highest
// (distance when the tag is at or ahead of the frame, twice the distance when
// behind; the lowest slot wins a tie). A lookup reports the lowest valid slot
// holding the frame number. Every request yields exactly one result transfer,
// and every result carries the running byte total in MiB, saturated at 1023.
// A lookup and a store of nonzero size scan the slot memory through its single
// read port, one slot per cycle, scoring each slot from the registered read
// data; a store then writes its chosen slot and updates the byte total. Clear,
// zero-size store and code 3 skip the scan and go straight to the result stage,
// which waits for a free output register. The input is ready again the cycle
// after the result loads. One request is in flight at a time; the input is
// ready again once its result sits in the output register, even if that result
// has not yet been taken. No clearing pass runs after reset: valid bits reset
// in flip-flops.
module frame_cache_distance_replacement
    import fcdr_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [FRAME_W-1:0]   frame_number,
    input  wire logic [BYTES_W-1:0]   frame_bytes,
    input  wire logic [FMT_W-1:0]     frame_format,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      hit,
    output logic                      stored,
    output logic [IDX_OUT_W-1:0]      slot_id,
    output logic [BYTES_W-1:0]        held_bytes,
    output logic [FMT_W-1:0]          held_format,
    output logic [MIB_W-1:0]          total_mib
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cmd_t              cmd;
    stat_t             st;
    logic [SLOT_W-1:0] rd_addr;

    // sequencer: owns the scan counter and decides each cycle's command
    fcdr_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    // datapath: slot memory, scoring, byte total and the output register
    fcdr_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .req_type     (req_type),
        .frame_number (frame_number),
        .frame_bytes  (frame_bytes),
        .frame_format (frame_format),
        .out_ready    (out_ready),
        .st           (st),
        .out_valid    (out_valid),
        .hit          (hit),
        .stored       (stored),
        .slot_id      (slot_id),
        .held_bytes   (held_bytes),
        .held_format  (held_format),
        .total_mib    (total_mib)
    );

endmodule

`default_nettype wire

@@ verif/frame_cache_checker.sv @@
// Channel monitor, slot-table predictor and result comparison for the frame cache.
`timescale 1ns / 1ps

module frame_cache_checker
    import fcdr_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [FRAME_W-1:0]   frame_number,
    input  wire logic [BYTES_W-1:0]   frame_bytes,
    input  wire logic [FMT_W-1:0]     frame_format,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic                 hit,
    input  wire logic                 stored,
    input  wire logic [IDX_OUT_W-1:0] slot_id,
    input  wire logic [BYTES_W-1:0]   held_bytes,
    input  wire logic [FMT_W-1:0]     held_format,
    input  wire logic [MIB_W-1:0]     total_mib,
    output int                        errors,
    output int                        pending
);

    localparam logic [MIB_W-1:0] MIB_CEIL = '1;

    typedef struct packed {
        logic                 hit;
        logic                 stored;
        logic [IDX_OUT_W-1:0] slot_id;
        logic [BYTES_W-1:0]   held_bytes;
        logic [FMT_W-1:0]     held_format;
        logic [MIB_W-1:0]     total_mib;
    } cache_reply_t;

    logic         slot_used [SLOTS];
    entry_t       slot_tag  [SLOTS];
    logic [31:0]  bytes_held;
    cache_reply_t reply_fifo [$];

    // distance when the tag is at or ahead of the frame, twice it when behind
    function automatic logic [32:0] distance_score(input logic [FRAME_W-1:0] tag,
                                                   input logic [FRAME_W-1:0] frame);
        logic [32:0] t;
        logic [32:0] f;
        t = {2'b00, tag};
        f = {2'b00, frame};
        if (t >= f)
            return t - f;
        return (f - t) << 1;
    endfunction

    // apply one request to the shadow table and return the result it yields
    function automatic cache_reply_t serve_request(input logic [REQ_W-1:0]   kind,
                                                   input logic [FRAME_W-1:0] frame,
                                                   input logic [BYTES_W-1:0] nbytes,
                                                   input logic [FMT_W-1:0]   fmt);
        cache_reply_t r;
        int           slot;
        logic [32:0]  best_score;
        logic [32:0]  s;
        logic [31:0]  mib;
        r = '0;
        if (kind == REQ_STORE) begin
            if (nbytes != '0) begin
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!slot_used[i] && slot < 0)
                        slot = i;
                if (slot < 0) begin
                    slot = 0;
                    best_score = distance_score(slot_tag[0].frame, frame);
                    for (int i = 1; i < SLOTS; i++) begin
                        s = distance_score(slot_tag[i].frame, frame);
                        if (s > best_score) begin
                            best_score = s;
                            slot = i;
                        end
                    end
                end
                if (slot_used[slot])
                    bytes_held = bytes_held - slot_tag[slot].nbytes;
                slot_used[slot]       = 1'b1;
                slot_tag[slot].frame  = frame;
                slot_tag[slot].nbytes = nbytes;
                slot_tag[slot].fmt    = fmt;
                bytes_held = bytes_held + nbytes;
                r.stored  = 1'b1;
                r.slot_id = slot[IDX_OUT_W-1:0];
            end
        end
        else if (kind == REQ_LOOKUP) begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot < 0 && slot_used[i] && slot_tag[i].frame == frame)
                    slot = i;
            if (slot >= 0) begin
                r.hit         = 1'b1;
                r.slot_id     = slot[IDX_OUT_W-1:0];
                r.held_bytes  = slot_tag[slot].nbytes;
                r.held_format = slot_tag[slot].fmt;
            end
        end
        else if (kind == REQ_CLEAR) begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            bytes_held = '0;
        end
        mib = bytes_held >> MIB_SHIFT;
        r.total_mib = (mib > 32'(MIB_CEIL)) ? MIB_CEIL : mib[MIB_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cache_reply_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i] = 1'b0;
                slot_tag[i]  = '0;
            end
            bytes_held = '0;
            reply_fifo.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (in_valid && in_ready)
                reply_fifo.push_back(serve_request(req_type, frame_number,
                                                   frame_bytes, frame_format));
            if (out_valid && out_ready) begin
                if (reply_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, expected none, actual %h",
                             $time, {hit, stored, slot_id, held_bytes, held_format, total_mib});
                end
                else begin
                    want = reply_fifo.pop_front();
                    check_field("hit", 32'(want.hit), 32'(hit));
                    check_field("stored", 32'(want.stored), 32'(stored));
                    check_field("slot_id", 32'(want.slot_id), 32'(slot_id));
                    check_field("held_bytes", 32'(want.held_bytes), 32'(held_bytes));
                    check_field("held_format", 32'(want.held_format), 32'(held_format));
                    check_field("total_mib", 32'(want.total_mib), 32'(total_mib));
                end
            end
            pending = reply_fifo.size();
        end
    end

endmodule

@@ verif/frame_cache_distance_replacement_tb.sv @@
// Stimulus, reset, clock and verdict for the frame cache tag table.
`timescale 1ns / 1ps

module frame_cache_distance_replacement_tb
    import fcdr_pkg::*;
();

    localparam int SLOTS = 16;
    // request code the block must treat as a no-op
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
    localparam logic [FMT_W-1:0]   FMT_MAX   = '1;
    // requests in the random part, and where idling stops
    localparam int RANDOM_ITEMS = 700;
    localparam int QUIET_FROM   = 620;
    // receiver hold-off: start cycle and length
    localparam int HOLD_AT  = 3000;
    localparam int HOLD_LEN = 150;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type     = REQ_STORE;
    logic [FRAME_W-1:0]   frame_number = '0;
    logic [BYTES_W-1:0]   frame_bytes  = '0;
    logic [FMT_W-1:0]     frame_format = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 hit;
    logic                 stored;
    logic [IDX_OUT_W-1:0] slot_id;
    logic [BYTES_W-1:0]   held_bytes;
    logic [FMT_W-1:0]     held_format;
    logic [MIB_W-1:0]     total_mib;

    int errors;
    int pending;
    // set for the last part of the run: no idling on either side
    bit quiet = 1'b0;
    // frames stored lately, so lookups hit often
    logic [FRAME_W-1:0] recent_frames [$];

    frame_cache_distance_replacement #(
        .SLOTS (SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_number (frame_number),
        .frame_bytes  (frame_bytes),
        .frame_format (frame_format),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .stored       (stored),
        .slot_id      (slot_id),
        .held_bytes   (held_bytes),
        .held_format  (held_format),
        .total_mib    (total_mib)
    );

    frame_cache_checker #(
        .SLOTS (SLOTS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_number (frame_number),
        .frame_bytes  (frame_bytes),
        .frame_format (frame_format),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .stored       (stored),
        .slot_id      (slot_id),
        .held_bytes   (held_bytes),
        .held_format  (held_format),
        .total_mib    (total_mib),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one request and hold it until the block takes the transfer.
    // An optional idle burst goes in front of it.
    task automatic send_request(input logic [REQ_W-1:0]   kind,
                                input logic [FRAME_W-1:0] frame,
                                input logic [BYTES_W-1:0] nbytes,
                                input logic [FMT_W-1:0]   fmt);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= kind;
        frame_number <= frame;
        frame_bytes  <= nbytes;
        frame_format <= fmt;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Pick a frame number close to base, so scores tie and tags fall on both
    // sides of the frame; now and then any frame at all.
    function automatic logic [FRAME_W-1:0] near_frame(input logic [FRAME_W-1:0] base,
                                                      input int span);
        int          off;
        logic [31:0] raw;
        if ($urandom_range(0, 9) == 0) begin
            raw = $urandom();
            return raw[FRAME_W-1:0];
        end
        off = $urandom_range(0, 2 * span) - span;
        return base + off[FRAME_W-1:0];
    endfunction

    // Size per episode mode: small, any (zero included), or mostly the maximum.
    function automatic logic [BYTES_W-1:0] pick_size(input int mode);
        logic [31:0] raw;
        raw = $urandom();
        case (mode)
            0:       return BYTES_W'($urandom_range(1, 4096));
            1:       return raw[BYTES_W-1:0];
            default: return ($urandom_range(0, 3) != 0) ? BYTES_MAX
                                                        : BYTES_MAX - raw[9:0];
        endcase
    endfunction

    // Receiver: ready most of the time, short random stalls, and once a long
    // hold-off so that the block fills up and stalls its input.
    initial
    begin : receiver
        int unsigned cycle;
        int unsigned stall;
        bit          held_long;
        cycle     = 0;
        held_long = 1'b0;
        wait (rst_n == 1'b1);
        @(posedge clk);
        forever begin
            if (!held_long && cycle >= HOLD_AT) begin
                held_long = 1'b1;
                out_ready <= 1'b0;
                stall = HOLD_LEN;
            end
            else if (!quiet && $urandom_range(0, 6) == 0) begin
                out_ready <= 1'b0;
                stall = $urandom_range(1, 3);
            end
            else begin
                out_ready <= 1'b1;
                stall = 1;
            end
            repeat (stall) @(posedge clk);
            cycle += stall;
        end
    end

    initial
    begin : stimulus
        logic [FRAME_W-1:0] base;
        logic [FRAME_W-1:0] frame;
        logic [BYTES_W-1:0] nbytes;
        logic [31:0]        raw;
        int                 counted;
        int                 size_mode;
        int                 span;
        int                 pick;
        int                 drain;

        // hold reset low from the start, then release it at a rising edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: field extremes, every request kind, and the special
        // cases (zero-size store, duplicate frame, lookup miss, clear, unused code).
        send_request(REQ_LOOKUP, '0, '0, '0);                 // miss on the empty table
        send_request(REQ_STORE, '0, '0, FMT_MAX);             // zero-size store, ignored
        send_request(REQ_STORE, FRAME_MAX, BYTES_MAX, FMT_MAX);
        send_request(REQ_STORE, '0, BYTES_W'(1), '0);
        send_request(REQ_STORE, FRAME_MAX, BYTES_W'(1 << MIB_SHIFT), 8'hA5);  // duplicate
        send_request(REQ_LOOKUP, FRAME_MAX, '0, '0);          // lowest matching slot
        send_request(REQ_LOOKUP, '0, BYTES_MAX, FMT_MAX);
        send_request(REQ_LOOKUP, FRAME_W'(12345), '0, '0);    // miss
        send_request(REQ_UNUSED, FRAME_MAX, BYTES_MAX, FMT_MAX);
        send_request(REQ_CLEAR, FRAME_MAX, BYTES_MAX, FMT_MAX);
        send_request(REQ_LOOKUP, FRAME_MAX, '0, '0);          // miss after clear
        send_request(REQ_STORE, FRAME_W'(1000), BYTES_MAX, 8'h01);
        send_request(REQ_STORE, FRAME_W'(999), BYTES_MAX, 8'h80);
        send_request(REQ_STORE, FRAME_W'(1001), BYTES_MAX, 8'h7F);
        send_request(REQ_LOOKUP, FRAME_W'(999), '0, '0);
        send_request(REQ_CLEAR, '0, '0, '0);

        // Random part: episodes of well-formed traffic around one base frame,
        // long enough to fill the table and drive evictions, with some noise.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                send_request(REQ_CLEAR, near_frame('0, 8), pick_size(1), FMT_W'($urandom()));
                counted++;
            end
            raw = $urandom();
            case ($urandom_range(0, 3))
                0:       base = FRAME_W'($urandom_range(0, 64));
                1:       base = FRAME_MAX - FRAME_W'($urandom_range(0, 64));
                default: base = raw[FRAME_W-1:0];
            endcase
            size_mode = $urandom_range(0, 2);
            span      = $urandom_range(2, 60);
            repeat ($urandom_range(20, 60)) begin
                if (counted >= RANDOM_ITEMS)
                    break;
                pick = $urandom_range(0, 99);
                raw  = $urandom();
                if (pick < 50) begin
                    frame  = near_frame(base, span);
                    nbytes = pick_size(size_mode);
                    send_request(REQ_STORE, frame, nbytes, raw[FMT_W-1:0]);
                    if (nbytes != '0) begin
                        recent_frames.push_back(frame);
                        if (recent_frames.size() > 24)
                            void'(recent_frames.pop_front());
                    end
                end
                else if (pick < 88) begin
                    if (recent_frames.size() > 0 && $urandom_range(0, 9) < 7)
                        frame = recent_frames[$urandom_range(0, recent_frames.size() - 1)];
                    else
                        frame = near_frame(base, span);
                    send_request(REQ_LOOKUP, frame, raw[BYTES_W-1:0], raw[31:24]);
                end
                else if (pick < 90) begin
                    send_request(REQ_CLEAR, near_frame(base, span), raw[BYTES_W-1:0],
                                 raw[31:24]);
                end
                else if (pick < 95) begin
                    send_request(REQ_STORE, near_frame(base, span), '0, raw[FMT_W-1:0]);
                end
                else begin
                    send_request(REQ_UNUSED, near_frame(base, span), raw[BYTES_W-1:0],
                                 raw[31:24]);
                end
                counted++;
                if (counted >= QUIET_FROM)
                    quiet = 1'b1;
            end
        end

        // drop valid, then wait for every expected result at falling edges
        in_valid <= 1'b0;
        drain = 0;
        do begin
            @(negedge clk);
            drain++;
        end while (pending != 0 && drain < 5000);
        // allow a store's full latency for anything still in flight
        repeat (40) @(negedge clk);

        if (errors == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin : watchdog
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fcdr_pkg.sv
sv/fcdr_ctrl.sv
sv/fcdr_dp.sv
sv/frame_cache_distance_replacement.sv
verif/frame_cache_checker.sv
verif/frame_cache_distance_replacement_tb.sv
